// ===== rtl/psld_pkg.sv =====
// Package for the pending signal line drain block.
// Holds widths, operation codes, controller states and the command/status structs.
// No dependencies.
package psld_pkg;

  localparam int MAX_LINES = 64;
  localparam int LINE_W    = $clog2(MAX_LINES);
  localparam int CNT_W     = $clog2(MAX_LINES + 1);

  typedef enum logic [1:0] {
    KIND_TRIGGER = 2'd0,
    KIND_REVOKE  = 2'd1,
    KIND_PROCESS = 2'd2
  } kind_e;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_EXEC,
    ST_SCAN
  } state_e;

  typedef struct packed {
    logic capture;
    logic emit_single;
    logic start_scan;
    logic emit_scan;
    logic advance;
  } cmd_t;

  typedef struct packed {
    logic [1:0] kind;
    logic       out_free;
    logic       any_pending;
    logic       hit;
    logic       is_last;
  } status_t;

endpackage

// ===== rtl/psld_ctrl.sv =====
// Controller state machine for the pending signal line drain block.
// Sequences single updates and the drain scan; depends on psld_pkg.
module psld_ctrl (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              in_valid_i,
  input  psld_pkg::status_t status_i,
  output psld_pkg::cmd_t    cmd_o,
  output logic              in_stall_o
);
  import psld_pkg::*;

  state_e state_q, state_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  always_comb begin
    state_d = state_q;
    case (state_q)
      ST_IDLE: begin
        if (in_valid_i) state_d = ST_EXEC;
      end
      ST_EXEC: begin
        if (status_i.kind == KIND_PROCESS && status_i.any_pending) begin
          state_d = ST_SCAN;
        end else if (status_i.out_free) begin
          state_d = ST_IDLE;
        end
      end
      ST_SCAN: begin
        if (status_i.hit && status_i.out_free && status_i.is_last) state_d = ST_IDLE;
      end
      default: state_d = ST_IDLE;
    endcase
  end

  always_comb begin
    cmd_o      = '0;
    in_stall_o = 1'b1;
    case (state_q)
      ST_IDLE: begin
        in_stall_o    = 1'b0;
        cmd_o.capture = in_valid_i;
      end
      ST_EXEC: begin
        if (status_i.kind == KIND_PROCESS && status_i.any_pending) begin
          cmd_o.start_scan = 1'b1;
        end else begin
          cmd_o.emit_single = status_i.out_free;
        end
      end
      ST_SCAN: begin
        if (status_i.hit) begin
          cmd_o.emit_scan = status_i.out_free;
          cmd_o.advance   = status_i.out_free;
        end else begin
          cmd_o.advance = 1'b1;
        end
      end
      default: begin
        cmd_o = '0;
      end
    endcase
  end

`ifndef SYNTH
  a_emit_needs_room: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (cmd_o.emit_scan || cmd_o.emit_single) |-> status_i.out_free)
    else $error("result emitted while output register busy");

  a_emit_exclusive: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !(cmd_o.emit_scan && cmd_o.emit_single))
    else $error("single and scan results emitted together");

  a_scan_continues: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (cmd_o.emit_scan && !status_i.is_last) |=> state_q == ST_SCAN)
    else $error("scan left before last pending line");

  a_scan_not_empty: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_SCAN) |-> status_i.any_pending)
    else $error("scanning with nothing pending");
`endif

endmodule

// ===== rtl/psld_datapath.sv =====
// Datapath for the pending signal line drain block: pending bits, line count,
// request latch, scan pointer and output register. Depends on psld_pkg.
module psld_datapath (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          cfg_we_i,
  input  logic [psld_pkg::CNT_W-1:0]    cfg_wdata_i,
  input  logic [1:0]                    in_kind_i,
  input  logic [psld_pkg::LINE_W-1:0]   in_line_i,
  input  logic                          out_stall_i,
  input  psld_pkg::cmd_t                cmd_i,
  output psld_pkg::status_t             status_o,
  output logic                          out_valid_o,
  output logic [psld_pkg::LINE_W-1:0]   out_served_line_o,
  output logic                          out_line_valid_o,
  output logic                          out_was_clear_o,
  output logic                          out_range_error_o,
  output logic [psld_pkg::CNT_W-1:0]    out_served_count_o,
  output logic                          out_last_o
);
  import psld_pkg::*;

  logic [MAX_LINES-1:0] pending_q, pending_d;
  logic [CNT_W-1:0]     count_q;
  logic [1:0]           kind_q;
  logic [LINE_W-1:0]    line_q;
  logic [LINE_W-1:0]    idx_q;
  logic [CNT_W-1:0]     served_q;
  logic                 out_valid_q;
  logic [LINE_W-1:0]    sl_q;
  logic                 lv_q, wc_q, re_q, last_q;
  logic [CNT_W-1:0]     cnt_q;

  logic [CNT_W-1:0]     eff;
  logic [MAX_LINES-1:0] valid_mask, above_mask, live;
  logic                 ok, is_upd, wc;
  logic [CNT_W-1:0]     served_inc;

  assign eff = (count_q > CNT_W'(MAX_LINES)) ? CNT_W'(MAX_LINES) : count_q;

  always_comb begin
    for (int i = 0; i < MAX_LINES; i++) begin
      valid_mask[i] = CNT_W'(i) < eff;
      above_mask[i] = LINE_W'(i) > idx_q;
    end
  end

  assign live       = pending_q & valid_mask;
  assign ok         = {1'b0, line_q} < eff;
  assign is_upd     = (kind_q == KIND_TRIGGER) || (kind_q == KIND_REVOKE);
  assign wc         = (kind_q == KIND_REVOKE) && ok && !pending_q[line_q];
  assign served_inc = served_q + CNT_W'(1);

  assign status_o.kind        = kind_q;
  assign status_o.out_free    = !out_valid_q || !out_stall_i;
  assign status_o.any_pending = |live;
  assign status_o.hit         = live[idx_q];
  assign status_o.is_last     = ~|(live & above_mask);

  always_comb begin
    pending_d = pending_q;
    if (cmd_i.emit_single && ok) begin
      if (kind_q == KIND_TRIGGER) pending_d[line_q] = 1'b1;
      if (kind_q == KIND_REVOKE)  pending_d[line_q] = 1'b0;
    end
    if (cmd_i.emit_scan) pending_d[idx_q] = 1'b0;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pending_q   <= '0;
      count_q     <= CNT_W'(MAX_LINES);
      out_valid_q <= 1'b0;
    end else begin
      pending_q <= pending_d;
      if (cfg_we_i) count_q <= cfg_wdata_i;
      if (cmd_i.emit_single || cmd_i.emit_scan) begin
        out_valid_q <= 1'b1;
      end else if (!out_stall_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.capture) begin
      kind_q <= in_kind_i;
      line_q <= in_line_i;
    end
    if (cmd_i.start_scan) begin
      idx_q    <= '0;
      served_q <= '0;
    end else if (cmd_i.advance) begin
      idx_q <= idx_q + LINE_W'(1);
    end
    if (cmd_i.emit_scan) served_q <= served_inc;
    if (cmd_i.emit_single) begin
      sl_q   <= line_q;
      lv_q   <= 1'b0;
      wc_q   <= wc;
      re_q   <= is_upd && !ok;
      cnt_q  <= '0;
      last_q <= 1'b1;
    end else if (cmd_i.emit_scan) begin
      sl_q   <= idx_q;
      lv_q   <= 1'b1;
      wc_q   <= 1'b0;
      re_q   <= 1'b0;
      cnt_q  <= served_inc;
      last_q <= status_o.is_last;
    end
  end

  assign out_valid_o        = out_valid_q;
  assign out_served_line_o  = sl_q;
  assign out_line_valid_o   = lv_q;
  assign out_was_clear_o    = wc_q;
  assign out_range_error_o  = re_q;
  assign out_served_count_o = cnt_q;
  assign out_last_o         = last_q;

endmodule

// ===== rtl/pending_signal_line_drain_core.sv =====
// Top level of the pending signal line drain block.
// Joins psld_ctrl and psld_datapath; depends on psld_pkg.
//
//  channel | handshake               | payload
//  --------+-------------------------+-----------------------------------------
//  in      | in_valid_i / in_stall_o | in_kind_i, in_line_i
//  out     | out_valid_o/out_stall_i | served_line, line_valid, was_clear,
//          |                         | range_error, served_count, last
//  cfg     | cfg_we_i                | cfg_wdata_i (line_count)
//
// Trigger, revoke and unknown requests are accepted, then apply any in-range update and
// load the output register once it is free. A process request with lines pending below
// the count scans up to the highest of them, one bit a cycle unless a stalled output
// holds it at a pending line; with none pending it loads one result. Reset clears the
// pending bits and sets the line count to 64. A request is taken while a result waits.
module pending_signal_line_drain_core (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        cfg_we_i,
  input  logic [psld_pkg::CNT_W-1:0]  cfg_wdata_i,
  input  logic                        in_valid_i,
  output logic                        in_stall_o,
  input  logic [1:0]                  in_kind_i,
  input  logic [psld_pkg::LINE_W-1:0] in_line_i,
  output logic                        out_valid_o,
  input  logic                        out_stall_i,
  output logic [psld_pkg::LINE_W-1:0] out_served_line_o,
  output logic                        out_line_valid_o,
  output logic                        out_was_clear_o,
  output logic                        out_range_error_o,
  output logic [psld_pkg::CNT_W-1:0]  out_served_count_o,
  output logic                        out_last_o
);
  import psld_pkg::*;

  cmd_t    cmd;
  status_t status;

  psld_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .status_i   (status),
    .cmd_o      (cmd),
    .in_stall_o (in_stall_o)
  );

  psld_datapath u_datapath (
    .clk_i              (clk_i),
    .rst_ni             (rst_ni),
    .cfg_we_i           (cfg_we_i),
    .cfg_wdata_i        (cfg_wdata_i),
    .in_kind_i          (in_kind_i),
    .in_line_i          (in_line_i),
    .out_stall_i        (out_stall_i),
    .cmd_i              (cmd),
    .status_o           (status),
    .out_valid_o        (out_valid_o),
    .out_served_line_o  (out_served_line_o),
    .out_line_valid_o   (out_line_valid_o),
    .out_was_clear_o    (out_was_clear_o),
    .out_range_error_o  (out_range_error_o),
    .out_served_count_o (out_served_count_o),
    .out_last_o         (out_last_o)
  );

endmodule
